[sv/single_link_clustering_core_assert.svh]
// ---------------------------------------------------------------------------
// single_link_clustering_core assertion macros
// shared property macros for the clustering core
// ---------------------------------------------------------------------------
`ifndef SINGLE_LINK_CLUSTERING_CORE_ASSERT_SVH
`define SINGLE_LINK_CLUSTERING_CORE_ASSERT_SVH

`ifndef SYNTH
// property that must hold at every edge out of reset
`define SLC_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: lbl");
// antecedent implies consequent in the same cycle
`define SLC_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: lbl");
`else
`define SLC_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define SLC_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`endif

`endif

[sv/slc_pkg.sv]
// ---------------------------------------------------------------------------
// slc_pkg
// shared types and constants of the single-linkage clustering core
// ---------------------------------------------------------------------------
`default_nettype none

package slc_pkg;

    localparam int MAX_ITEMS  = 16;
    localparam int IDX_BITS   = $clog2(MAX_ITEMS);
    localparam int CNT_BITS   = IDX_BITS + 1;
    localparam int DIST_BITS  = 16;
    localparam int ADDR_BITS  = 2 * IDX_BITS;
    localparam int CFG_BITS   = 5;

    localparam logic [CFG_BITS-1:0] ITEM_COUNT_RESET = CFG_BITS'(16);

    typedef struct packed {
        logic [3:0]  entry_row;
        logic [3:0]  entry_col;
        logic [15:0] entry_value;
        logic        entry_last;
    } entry_t;

    typedef struct packed {
        logic [3:0]  first_cluster;
        logic [3:0]  second_cluster;
        logic [15:0] link_distance;
        logic        last_merge;
    } merge_t;

endpackage

`default_nettype wire

[sv/slc_dist_ram.sv]
// ---------------------------------------------------------------------------
// slc_dist_ram
// distance store: one write port, two registered read ports
// ---------------------------------------------------------------------------
`default_nettype none

module slc_dist_ram #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 16
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_a_en,
    input  wire logic [ADDR_W-1:0] rd_a_addr,
    output logic      [DATA_W-1:0] rd_a_data,
    input  wire logic              rd_b_en,
    input  wire logic [ADDR_W-1:0] rd_b_addr,
    output logic      [DATA_W-1:0] rd_b_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds while the port is not enabled
    always_ff @(posedge clk)
    begin
        if (rd_a_en)
        begin
            rd_a_data <= mem[rd_a_addr];
        end
        if (rd_b_en)
        begin
            rd_b_data <= mem[rd_b_addr];
        end
    end

endmodule

`default_nettype wire

[sv/single_link_clustering_core.sv]
// ---------------------------------------------------------------------------
// single_link_clustering_core
// single-linkage clustering of a distance matrix with next-best-merge array
// ---------------------------------------------------------------------------
// usage:
//   entry channel (entry_valid / entry_stall): one matrix entry per beat,
//   written into the distance ram as it is taken; entry_stall is low while
//   loading, so entries stream at one beat per cycle.
//   a beat with entry_last set starts a run; entry_stall stays high until
//   the run ends, after the row rescan that follows the last merge.
//   merge channel (merge_valid / merge_stall): one record per merge from an
//   output register; the run continues while a record waits, and only
//   holds at the next record if the previous one is still stalled.
//   cfg channel (cfg_valid / cfg_ready): item_count, taken only while
//   loading; out-of-range values clamp to 2..16.
//   run sequence: an initial scan of every row, then per merge a find,
//   a pick, an emit, a row/column update and a rescan of the merged row;
//   the update writes the row and column entries in separate steps, as
//   the distance ram has a single write port.
//   reset: loading, item_count 16, no record pending; the distance ram is
//   not cleared, every entry a run reads must be written first.
// ---------------------------------------------------------------------------
`default_nettype none

`include "single_link_clustering_core_assert.svh"

module single_link_clustering_core
    import slc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                entry_valid,
    output logic                     entry_stall,
    input  wire entry_t              entry,
    output logic                     merge_valid,
    input  wire logic                merge_stall,
    output merge_t                   merge_rec,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [CFG_BITS-1:0] cfg_data
);

    // controller states
    localparam logic [2:0] S_LOAD    = 3'd0;
    localparam logic [2:0] S_RSC     = 3'd1;  // rescan one row
    localparam logic [2:0] S_FIND    = 3'd2;  // pick smallest next-best
    localparam logic [2:0] S_PICK    = 3'd3;  // resolve partner, read link
    localparam logic [2:0] S_EMIT    = 3'd4;  // load merge record
    localparam logic [2:0] S_UPD_RD  = 3'd5;  // read both rows for column j
    localparam logic [2:0] S_UPD_WR1 = 3'd6;  // write row entry
    localparam logic [2:0] S_UPD_WR2 = 3'd7;  // write column entry

    localparam logic [DIST_BITS-1:0] DIST_ONES = '1;

    logic [2:0]           state_reg;
    logic [CFG_BITS-1:0]  item_count_reg;
    logic [CNT_BITS-1:0]  n_items;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic [IDX_BITS-1:0]  cnt_idx;
    logic [IDX_BITS-1:0]  row_reg;
    logic [IDX_BITS-1:0]  k_reg;        // merge count
    logic                 rsc_all_reg;  // initial scan of every row
    logic                 pend_v_reg;
    logic                 found_reg;
    logic [DIST_BITS-1:0] bd_reg;
    logic [IDX_BITS-1:0]  bp_reg;
    logic [IDX_BITS-1:0]  f_reg;
    logic [IDX_BITS-1:0]  s_reg;
    logic                 out_valid_reg;
    merge_t               out_reg;

    logic [IDX_BITS-1:0]  rep_reg    [MAX_ITEMS];
    logic [DIST_BITS-1:0] best_d_reg [MAX_ITEMS];
    logic [IDX_BITS-1:0]  best_p_reg [MAX_ITEMS];

    // ram ports
    logic                 wr_en;
    logic [ADDR_BITS-1:0] wr_addr;
    logic [DIST_BITS-1:0] wr_data;
    logic                 rd_a_en;
    logic [ADDR_BITS-1:0] rd_a_addr;
    logic [DIST_BITS-1:0] rd_a_data;
    logic                 rd_b_en;
    logic [ADDR_BITS-1:0] rd_b_addr;
    logic [DIST_BITS-1:0] rd_b_data;

    logic                 entry_take;
    logic                 issue;
    logic                 found_next;
    logic [DIST_BITS-1:0] bd_next;
    logic [IDX_BITS-1:0]  bp_next;
    logic                 last_row;
    logic                 last_merge_now;
    logic                 slot_free;
    logic [IDX_BITS-1:0]  p_raw;
    logic [IDX_BITS-1:0]  p_sel;
    logic [IDX_BITS-1:0]  s_raw;
    logic [IDX_BITS-1:0]  s_sel;
    logic                 upd_active;
    logic [DIST_BITS-1:0] min_val;

    // clamp item_count to 2..MAX_ITEMS
    always_comb
    begin
        if (item_count_reg < CFG_BITS'(2))
        begin
            n_items = CNT_BITS'(2);
        end
        else if ({1'b0, item_count_reg} > (CFG_BITS + 1)'(MAX_ITEMS))
        begin
            n_items = CNT_BITS'(MAX_ITEMS);
        end
        else
        begin
            n_items = CNT_BITS'(item_count_reg);
        end
    end

    assign cnt_idx        = cnt_reg[IDX_BITS-1:0];
    assign entry_stall    = (state_reg != S_LOAD);
    assign cfg_ready      = (state_reg == S_LOAD);
    assign entry_take     = entry_valid && !entry_stall;
    assign merge_valid    = out_valid_reg;
    assign merge_rec      = out_reg;
    assign slot_free      = !out_valid_reg || !merge_stall;
    assign issue          = (cnt_reg < n_items);
    assign last_row       = ({1'b0, row_reg} == n_items - CNT_BITS'(1));
    assign last_merge_now = ({1'b0, k_reg} == n_items - CNT_BITS'(2));

    // running minimum of the row being scanned, pending ram data folded in
    always_comb
    begin
        found_next = found_reg;
        bd_next    = bd_reg;
        bp_next    = bp_reg;
        if (pend_v_reg && (!found_reg || rd_a_data < bd_reg))
        begin
            found_next = 1'b1;
            bd_next    = rd_a_data;
            bp_next    = s_reg;
        end
    end

    // partner of the chosen cluster, folded onto its current representative
    always_comb
    begin
        p_raw = best_p_reg[f_reg];
        p_sel = ({1'b0, p_raw} < n_items) ? p_raw : f_reg;
        s_raw = rep_reg[p_sel];
        s_sel = ({1'b0, s_raw} < n_items) ? s_raw : f_reg;
    end

    assign upd_active = (rep_reg[cnt_idx] == cnt_idx) && (cnt_idx != f_reg)
                        && (cnt_idx != s_reg);
    assign min_val    = (rd_a_data < rd_b_data) ? rd_a_data : rd_b_data;

    // ram port steering
    always_comb
    begin
        wr_en     = 1'b0;
        wr_addr   = {entry.entry_row, entry.entry_col};
        wr_data   = entry.entry_value;
        rd_a_en   = 1'b0;
        rd_a_addr = {row_reg, cnt_idx};
        rd_b_en   = 1'b0;
        rd_b_addr = {s_reg, cnt_idx};
        unique case (state_reg)
            S_LOAD:
            begin
                wr_en = entry_take;
            end
            S_RSC:
            begin
                rd_a_en = issue;
            end
            S_PICK:
            begin
                rd_a_en   = 1'b1;
                rd_a_addr = {f_reg, s_sel};
            end
            S_UPD_RD:
            begin
                rd_a_en   = issue && upd_active;
                rd_a_addr = {f_reg, cnt_idx};
                rd_b_en   = issue && upd_active;
            end
            S_UPD_WR1:
            begin
                wr_en   = 1'b1;
                wr_addr = {f_reg, cnt_idx};
                wr_data = min_val;
            end
            S_UPD_WR2:
            begin
                wr_en   = 1'b1;
                wr_addr = {cnt_idx, f_reg};
                wr_data = min_val;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    slc_dist_ram #(
        .ADDR_W (ADDR_BITS),
        .DATA_W (DIST_BITS)
    ) u_dist_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_a_en   (rd_a_en),
        .rd_a_addr (rd_a_addr),
        .rd_a_data (rd_a_data),
        .rd_b_en   (rd_b_en),
        .rd_b_addr (rd_b_addr),
        .rd_b_data (rd_b_data)
    );

    // sequencer; s_reg doubles as the column tag of the pending scan read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            item_count_reg <= ITEM_COUNT_RESET;
            cnt_reg        <= '0;
            row_reg        <= '0;
            k_reg          <= '0;
            rsc_all_reg    <= 1'b0;
            pend_v_reg     <= 1'b0;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < MAX_ITEMS; i++)
            begin
                rep_reg[i] <= IDX_BITS'(i);
            end
        end
        else
        begin
            // beat taken and no new record loaded behind it
            if (out_valid_reg && !merge_stall && (state_reg != S_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_LOAD:
                begin
                    if (cfg_valid)
                    begin
                        item_count_reg <= cfg_data;
                    end
                    if (entry_take && entry.entry_last)
                    begin
                        for (int i = 0; i < MAX_ITEMS; i++)
                        begin
                            rep_reg[i] <= IDX_BITS'(i);
                        end
                        k_reg       <= '0;
                        row_reg     <= '0;
                        cnt_reg     <= '0;
                        rsc_all_reg <= 1'b1;
                        pend_v_reg  <= 1'b0;
                        found_reg   <= 1'b0;
                        bd_reg      <= DIST_ONES;
                        bp_reg      <= '0;
                        state_reg   <= S_RSC;
                    end
                end
                S_RSC:
                begin
                    if (issue)
                    begin
                        found_reg  <= found_next;
                        bd_reg     <= bd_next;
                        bp_reg     <= bp_next;
                        pend_v_reg <= (cnt_idx != row_reg) && (rep_reg[cnt_idx] == cnt_idx);
                        s_reg      <= cnt_idx;
                        cnt_reg    <= cnt_reg + CNT_BITS'(1);
                    end
                    else
                    begin
                        pend_v_reg          <= 1'b0;
                        best_d_reg[row_reg] <= bd_next;
                        best_p_reg[row_reg] <= bp_next;
                        cnt_reg             <= '0;
                        found_reg           <= 1'b0;
                        if (rsc_all_reg && !last_row)
                        begin
                            row_reg <= row_reg + IDX_BITS'(1);
                            bd_reg  <= DIST_ONES;
                            bp_reg  <= row_reg + IDX_BITS'(1);
                        end
                        else if (!rsc_all_reg && last_merge_now)
                        begin
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            if (!rsc_all_reg)
                            begin
                                k_reg <= k_reg + IDX_BITS'(1);
                            end
                            state_reg <= S_FIND;
                        end
                    end
                end
                S_FIND:
                begin
                    if ((rep_reg[cnt_idx] == cnt_idx)
                        && (!found_reg || best_d_reg[cnt_idx] < bd_reg))
                    begin
                        found_reg <= 1'b1;
                        bd_reg    <= best_d_reg[cnt_idx];
                        f_reg     <= cnt_idx;
                    end
                    if (cnt_reg == n_items - CNT_BITS'(1))
                    begin
                        state_reg <= S_PICK;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNT_BITS'(1);
                    end
                end
                S_PICK:
                begin
                    s_reg     <= s_sel;
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg          <= 1'b1;
                        out_reg.first_cluster  <= 4'(f_reg);
                        out_reg.second_cluster <= 4'(s_reg);
                        out_reg.link_distance  <= 16'(rd_a_data);
                        out_reg.last_merge     <= last_merge_now;
                        cnt_reg                <= '0;
                        state_reg              <= S_UPD_RD;
                    end
                end
                S_UPD_RD:
                begin
                    if (!issue)
                    begin
                        row_reg     <= f_reg;
                        cnt_reg     <= '0;
                        rsc_all_reg <= 1'b0;
                        pend_v_reg  <= 1'b0;
                        found_reg   <= 1'b0;
                        bd_reg      <= DIST_ONES;
                        bp_reg      <= f_reg;
                        state_reg   <= S_RSC;
                    end
                    else
                    begin
                        if (rep_reg[cnt_idx] == s_reg)
                        begin
                            rep_reg[cnt_idx] <= f_reg;
                        end
                        if (upd_active)
                        begin
                            state_reg <= S_UPD_WR1;
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg + CNT_BITS'(1);
                        end
                    end
                end
                S_UPD_WR1:
                begin
                    state_reg <= S_UPD_WR2;
                end
                S_UPD_WR2:
                begin
                    cnt_reg   <= cnt_reg + CNT_BITS'(1);
                    state_reg <= S_UPD_RD;
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    // merge count never runs past n-2 during a run
    `SLC_ASSERT_ALWAYS(a_merge_count_range, clk, rst_n,
        (state_reg == S_LOAD) || ({1'b0, k_reg} + CNT_BITS'(2) <= n_items))
    // a new merge beat only comes out of the emit step
    `SLC_ASSERT_IMPLIES(a_beat_from_emit, clk, rst_n,
        $rose(merge_valid), $past(state_reg) == S_EMIT)
    // column counter stays within the matrix while updating
    `SLC_ASSERT_IMPLIES(a_update_count, clk, rst_n,
        (state_reg == S_UPD_WR1) || (state_reg == S_UPD_WR2), cnt_reg < n_items)

endmodule

`default_nettype wire

[dv/slc_merge_checker.sv]
// ---------------------------------------------------------------------------
// slc_merge_checker
// watches the entry, merge and cfg channels, predicts merge records and
// compares them field by field against the block's output
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module slc_merge_checker
    import slc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                entry_valid,
    input  logic                entry_stall,
    input  entry_t              entry,
    input  logic                merge_valid,
    input  logic                merge_stall,
    input  merge_t              merge_rec,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [CFG_BITS-1:0] cfg_data,
    output int                  fail_count,
    output int                  pending_merges
);

    logic [15:0] dist_mem [16][16];
    logic [3:0]  rep_of [16];
    logic [15:0] near_dist [16];
    logic [3:0]  near_idx [16];
    logic [4:0]  cfg_count;
    merge_t      merge_queue [$];

    assign pending_merges = merge_queue.size();

    function automatic int used_items();
        int n;
        n = cfg_count;
        if (n < 2) n = 2;
        if (n > 16) n = 16;
        return n;
    endfunction

    function automatic void rescan(int r, int n);
        logic        found;
        logic [15:0] bd;
        int          bp;
        found = 0;
        bd = 16'hffff;
        bp = r;
        for (int j = 0; j < n; j++) begin
            if (j == r || rep_of[j] != j) continue;
            if (!found || dist_mem[r][j] < bd) begin
                found = 1;
                bd = dist_mem[r][j];
                bp = j;
            end
        end
        near_dist[r] = bd;
        near_idx[r] = 4'(bp);
    endfunction

    function automatic void predict_merges();
        int          n, f, s, p;
        logic        found;
        logic [15:0] bd, a, b, m;
        merge_t      rec;
        n = used_items();
        for (int i = 0; i < n; i++) rep_of[i] = 4'(i);
        for (int i = 0; i < n; i++) rescan(i, n);
        for (int k = 0; k + 1 < n; k++) begin
            found = 0;
            f = 0;
            bd = 0;
            for (int j = 0; j < n; j++) begin
                if (rep_of[j] != j) continue;
                if (!found || near_dist[j] < bd) begin
                    found = 1;
                    bd = near_dist[j];
                    f = j;
                end
            end
            p = near_idx[f];
            if (p >= n) p = f;
            s = rep_of[p];
            if (s >= n) s = f;
            rec.first_cluster = 4'(f);
            rec.second_cluster = 4'(s);
            rec.link_distance = dist_mem[f][s];
            rec.last_merge = (k + 2 == n);
            merge_queue = {merge_queue, rec};
            for (int j = 0; j < n; j++) begin
                if (rep_of[j] == j && j != f && j != s) begin
                    a = dist_mem[f][j];
                    b = dist_mem[s][j];
                    m = (a < b) ? a : b;
                    dist_mem[f][j] = m;
                    dist_mem[j][f] = m;
                end
                if (rep_of[j] == s) rep_of[j] = 4'(f);
            end
            rescan(f, n);
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        merge_t want;
        int     errs;
        errs = 0;
        if (!rst_n) begin
            fail_count <= 0;
            cfg_count = ITEM_COUNT_RESET;
            merge_queue.delete();
        end else begin
            if (cfg_valid && cfg_ready) cfg_count = cfg_data;
            if (entry_valid && !entry_stall) begin
                dist_mem[entry.entry_row][entry.entry_col] = entry.entry_value;
                if (entry.entry_last) predict_merges();
            end
            if (merge_valid && !merge_stall) begin
                if (merge_queue.size() == 0) begin
                    $error("merge beat with no record expected");
                    errs++;
                end else begin
                    want = merge_queue.pop_front();
                    if (want.first_cluster !== merge_rec.first_cluster) begin
                        $error("first_cluster: expected %0d got %0d",
                               want.first_cluster, merge_rec.first_cluster);
                        errs++;
                    end
                    if (want.second_cluster !== merge_rec.second_cluster) begin
                        $error("second_cluster: expected %0d got %0d",
                               want.second_cluster, merge_rec.second_cluster);
                        errs++;
                    end
                    if (want.link_distance !== merge_rec.link_distance) begin
                        $error("link_distance: expected %0d got %0d",
                               want.link_distance, merge_rec.link_distance);
                        errs++;
                    end
                    if (want.last_merge !== merge_rec.last_merge) begin
                        $error("last_merge: expected %0d got %0d",
                               want.last_merge, merge_rec.last_merge);
                        errs++;
                    end
                end
            end
            if (errs != 0) fail_count <= fail_count + errs;
        end
    end

endmodule

[dv/tb.sv]
// ---------------------------------------------------------------------------
// tb
// stimulus for the clustering core: loads distance matrices of several
// sizes under random idling and stalls, the checker predicts the merges
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import slc_pkg::*;

    logic                clk;
    logic                rst_n;
    logic                entry_valid;
    logic                entry_stall;
    entry_t              entry;
    logic                merge_valid;
    logic                merge_stall;
    merge_t              merge_rec;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CFG_BITS-1:0] cfg_data;
    int                  fail_count;
    int                  pending_merges;

    // idle percentages for sender and receiver
    int send_idle_pct;
    int recv_stall_pct;
    // receiver hold-off stretch, counted in the receiver process
    int hold_cycles;

    single_link_clustering_core uut (
        .clk(clk), .rst_n(rst_n),
        .entry_valid(entry_valid), .entry_stall(entry_stall), .entry(entry),
        .merge_valid(merge_valid), .merge_stall(merge_stall), .merge_rec(merge_rec),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    slc_merge_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .entry_valid(entry_valid), .entry_stall(entry_stall), .entry(entry),
        .merge_valid(merge_valid), .merge_stall(merge_stall), .merge_rec(merge_rec),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending_merges(pending_merges)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            merge_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            merge_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // one entry beat; idle gaps fall before the beat, valid is left high
    // after the beat and the next call or drain() takes it down
    task automatic send_entry(input logic [3:0] r, input logic [3:0] c,
                              input logic [15:0] v, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            entry_valid <= 1'b0;
            @(negedge clk);
        end
        entry_valid <= 1'b1;
        entry <= '{entry_row: r, entry_col: c, entry_value: v, entry_last: last};
        @(posedge clk);
        while (entry_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // wait until every predicted merge beat has come, then let the core settle
    task automatic drain();
        entry_valid <= 1'b0;
        while (pending_merges != 0 || entry_stall)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_count(input logic [4:0] n);
        cfg_valid <= 1'b1;
        cfg_data <= n;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // load every off-diagonal entry of an n-by-n matrix, then mark last
    // mode 0 random, 1 all equal (ties), 2 max/no link, 3 zeros, 4 small range
    task automatic load_matrix(input int n, input int mode);
        logic [15:0] v;
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
            begin
                if (r == c)
                    continue;
                case (mode)
                    0: v = 16'($urandom);
                    1: v = 16'd777;
                    2: v = 16'hffff;
                    3: v = 16'd0;
                    default: v = 16'($urandom_range(3));
                endcase
                send_entry(4'(r), 4'(c), v, 1'b0);
            end
        // diagonal entry carries the last mark; never read by the run
        send_entry(4'(0), 4'(0), 16'($urandom), 1'b1);
    endtask

    initial
    begin
        #50_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        entry_valid = 1'b0;
        entry = '0;
        merge_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: smallest matrix, ties, no links, zeros, out-of-range counts
        write_count(5'd2);
        load_matrix(2, 0);
        drain();
        write_count(5'd3);
        load_matrix(3, 1);
        drain();
        write_count(5'd0);
        load_matrix(2, 2);
        drain();
        // entries outside the active size are stored but never read
        write_count(5'd3);
        send_entry(4'd15, 4'd15, 16'hffff, 1'b0);
        send_entry(4'd10, 4'd5, 16'h5a5a, 1'b0);
        load_matrix(3, 3);
        drain();

        // random phases over several sizes and idling mixes
        for (int ph = 0; ph < 4; ph++)
        begin
            int n;
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            n = 2 + $urandom_range(3);
            write_count(5'(n));
            load_matrix(n, $urandom_range(4) == 0 ? 4 : 0);
            drain();
        end

        // full size with a value above the clamp; long receiver hold-off
        // while the next entries are already offered, so the output
        // register backs up and entries stall
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_count(5'd31);
        hold_cycles = 3000;
        load_matrix(16, 0);
        recv_stall_pct = 40;
        send_entry(4'd0, 4'd1, 16'd5, 1'b0);
        send_entry(4'd1, 4'd0, 16'd6, 1'b0);
        send_entry(4'd0, 4'd2, 16'd7, 1'b0);
        send_entry(4'd2, 4'd0, 16'd8, 1'b0);
        drain();
        write_count(5'd3);
        load_matrix(3, 4);
        drain();

        if (fail_count == 0 && pending_merges == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
